FILE: hdl/pjr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjr_pkg: shared types and constants
// Beat formats for the input and result channels, the configuration set,
// and the record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package pjr_pkg;

    // Input beat: measured pixel, world point, pose quaternion, translation
    typedef struct packed {
        logic signed [31:0] meas_u;
        logic signed [31:0] meas_v;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } item_t;

    // Result beat: one image row
    typedef struct packed {
        logic               row_index;
        logic signed [31:0] error_value;
        logic signed [31:0] jac_rot_x;
        logic signed [31:0] jac_rot_y;
        logic signed [31:0] jac_rot_z;
        logic signed [31:0] jac_trans_x;
        logic signed [31:0] jac_trans_y;
        logic signed [31:0] jac_trans_z;
        logic               depth_bad;
        logic               last_row;
    } result_t;

    // Camera intrinsics, unsigned Q15.16
    typedef struct packed {
        logic [30:0] focal_x;
        logic [30:0] focal_y;
        logic [30:0] center_x;
        logic [30:0] center_y;
    } cfg_t;

    typedef enum logic [1:0] {
        CFG_FOCAL_X  = 2'd0,
        CFG_FOCAL_Y  = 2'd1,
        CFG_CENTER_X = 2'd2,
        CFG_CENTER_Y = 2'd3
    } cfg_idx_t;

    // Rotation entry at scale 2^26
    typedef logic signed [31:0] coef_t;

    // Front-to-back record: row-major rotation plus the original beat
    typedef struct packed {
        coef_t [8:0] rot;
        item_t       item;
    } work_t;

    // Intermediate Q16.16 values are 48 bits, saturated to +-(2^47 - 1)
    localparam logic [47:0] WIDE_MAX = 48'h7FFF_FFFF_FFFF;

endpackage : pjr_pkg
`default_nettype wire

FILE: hdl/pjr_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjr_fifo: small show-ahead queue
// Register-based queue; the head entry is visible while empty is low.
// ----------------------------------------------------------------------------
module pjr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule : pjr_fifo
`default_nettype wire

FILE: hdl/pjr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjr_front: input stage and rotation matrix
// Takes input beats, forms the quaternion products in one register stage
// and hands the rotation matrix, rounded to scale 2^26, to the work queue.
// ----------------------------------------------------------------------------
module pjr_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  pjr_pkg::item_t  item,
    output logic            work_push,
    input  logic            work_full,
    output pjr_pkg::work_t  work
);
    import pjr_pkg::*;

    localparam logic signed [34:0] ONE28 = 35'sd268435456;

    logic               stage_valid_reg;
    logic               take;
    item_t              item_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    logic signed [34:0] r28 [9];
    logic signed [34:0] r26 [9];

    assign full      = stage_valid_reg && work_full;
    assign take      = push && !full;
    assign work_push = stage_valid_reg;

    // Hold the stage until the work queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (!work_full)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    // Latch the beat and its quaternion products
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item;
            xx_reg   <= item.quat_x * item.quat_x;
            yy_reg   <= item.quat_y * item.quat_y;
            zz_reg   <= item.quat_z * item.quat_z;
            xy_reg   <= item.quat_x * item.quat_y;
            xz_reg   <= item.quat_x * item.quat_z;
            yz_reg   <= item.quat_y * item.quat_z;
            wx_reg   <= item.quat_w * item.quat_x;
            wy_reg   <= item.quat_w * item.quat_y;
            wz_reg   <= item.quat_w * item.quat_z;
        end
    end

    // Form rotation entries at scale 2^28, then round to 2^26
    always_comb
    begin
        r28[0] = ONE28 - ((35'(yy_reg) + 35'(zz_reg)) <<< 1);
        r28[1] = (35'(xy_reg) - 35'(wz_reg)) <<< 1;
        r28[2] = (35'(xz_reg) + 35'(wy_reg)) <<< 1;
        r28[3] = (35'(xy_reg) + 35'(wz_reg)) <<< 1;
        r28[4] = ONE28 - ((35'(xx_reg) + 35'(zz_reg)) <<< 1);
        r28[5] = (35'(yz_reg) - 35'(wx_reg)) <<< 1;
        r28[6] = (35'(xz_reg) - 35'(wy_reg)) <<< 1;
        r28[7] = (35'(yz_reg) + 35'(wx_reg)) <<< 1;
        r28[8] = ONE28 - ((35'(xx_reg) + 35'(yy_reg)) <<< 1);
        work.item = item_reg;
        for (int k = 0; k < 9; k++)
        begin
            r26[k]      = (r28[k] + 35'sd2) >>> 2;
            work.rot[k] = r26[k][31:0];
        end
    end

endmodule : pjr_front
`default_nettype wire

FILE: hdl/pjr_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjr_mul: sequential 48 x 48 unsigned multiplier
// One 48 x 16 partial product per cycle, most significant digit first;
// done pulses for one cycle when the 96-bit product is ready.
// ----------------------------------------------------------------------------
module pjr_mul
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] mag_a,
    input  logic [47:0] mag_b,
    output logic        done,
    output logic [95:0] prod
);
    localparam int DIGIT_W = 16;
    localparam int DIGITS  = 3;

    logic        busy_reg;
    logic        done_reg;
    logic [1:0]  cnt_reg;
    logic [47:0] a_reg;
    logic [47:0] b_reg;
    logic [95:0] acc_reg;
    logic [63:0] partial;

    assign partial = a_reg * b_reg[47 -: DIGIT_W];
    assign done    = done_reg;
    assign prod    = acc_reg;

    // Count digits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 2'(DIGITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift-accumulate one digit
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= mag_a;
            b_reg   <= mag_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[95-DIGIT_W:0], {DIGIT_W{1'b0}}} + 96'(partial);
            b_reg   <= {b_reg[47-DIGIT_W:0], {DIGIT_W{1'b0}}};
        end
    end

endmodule : pjr_mul
`default_nettype wire

FILE: hdl/pjr_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjr_div: restoring divider, one quotient bit per cycle
// Computes (num * 2^16 + floor(den / 2)) / den, i.e. a Q16.16 quotient
// rounded half up.
// ----------------------------------------------------------------------------
module pjr_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] num,
    input  logic [39:0] den,
    output logic        done,
    output logic [63:0] quot
);
    localparam int DW = 64;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dvd_reg;
    logic [39:0] den_reg;
    logic [40:0] rem_reg;
    logic [41:0] trial;
    logic [41:0] diff;
    logic        fits;

    assign trial = {rem_reg, dvd_reg[DW-1]};
    assign diff  = trial - {2'b00, den_reg};
    assign fits  = (trial >= {2'b00, den_reg});
    assign done  = done_reg;
    assign quot  = dvd_reg;

    // Count quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'(DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift dividend out, quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num, 16'h0000} + 64'(den >> 1);
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[40:0] : trial[40:0];
        end
    end

endmodule : pjr_div
`default_nettype wire

FILE: hdl/pjr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pjr_back: projection and Jacobian sequencer
// Pops one work record, forms the camera point and, for positive depth, the
// three quotients and the seventeen Q16.16 products on the shared multiplier
// and divider, and pushes the u row and the v row into the result queue.
// ----------------------------------------------------------------------------
module pjr_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              work_empty,
    output logic              work_pop,
    input  pjr_pkg::work_t    work,
    input  pjr_pkg::cfg_t     cfg,
    output logic              res_push,
    input  logic              res_full,
    output pjr_pkg::result_t  res
);
    import pjr_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAM,
        ST_CAM_WAIT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_QMUL,
        ST_QMUL_WAIT,
        ST_OUT_U,
        ST_OUT_V
    } state_t;

    typedef enum logic [1:0] {
        D_A,
        D_B,
        D_C
    } dstep_t;

    typedef enum logic [4:0] {
        Q_AB, Q_AA, Q_BB, Q_AC, Q_BC, Q_PU, Q_PV,
        Q_JU0, Q_JU1, Q_JU2, Q_JU3, Q_JU5,
        Q_JV0, Q_JV1, Q_JV2, Q_JV4, Q_JV5
    } qstep_t;

    localparam logic signed [49:0] Q_ONE   = 50'sd65536;
    localparam logic signed [65:0] ROUND26 = 66'sd33554432;
    localparam logic signed [40:0] NUM_ONE = 41'sd65536;

    state_t             state_reg;
    dstep_t             dstep_reg;
    qstep_t             qstep_reg;
    logic [1:0]         row_reg;
    logic [1:0]         col_reg;
    logic               bad_reg;

    work_t              work_reg;
    logic signed [65:0] acc_reg;
    logic signed [40:0] x_reg, y_reg, z_reg;
    logic signed [47:0] a_reg, b_reg, c_reg;
    logic signed [47:0] ab_reg, aa_reg, bb_reg, ac_reg, bc_reg;
    logic signed [31:0] eu_reg, ev_reg;
    logic signed [31:0] ju0_reg, ju1_reg, ju2_reg, ju3_reg, ju5_reg;
    logic signed [31:0] jv0_reg, jv1_reg, jv2_reg, jv4_reg, jv5_reg;

    logic [3:0]         rot_idx;
    logic signed [31:0] rot_sel;
    logic signed [31:0] p_sel;
    logic signed [31:0] t_sel;
    logic signed [49:0] opa, opb;
    logic [49:0]        mag_a_full, mag_b_full;
    logic               neg;
    logic               mul_start, mul_done;
    logic [95:0]        mul_prod;
    logic signed [65:0] cam_prod, cam_sum, cam_round;
    logic signed [40:0] cam_coord;
    logic [95:0]        q_rnd;
    logic [47:0]        q_mag;
    logic signed [47:0] qres;
    logic signed [31:0] qsat;
    logic signed [49:0] err_full;
    logic signed [31:0] err_sat;
    logic signed [40:0] dnum;
    logic [40:0]        dnum_mag;
    logic               div_start, div_done;
    logic [63:0]        div_quot;
    logic [47:0]        d_mag;
    logic signed [47:0] dres;
    logic               cam_step, div_step, qmul_step;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -50'sd2147483648)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Select camera-transform operands
    always_comb
    begin
        rot_idx = 4'(row_reg) * 4'd3 + 4'(col_reg);
        rot_sel = work_reg.rot[rot_idx];
        unique case (col_reg)
            2'd0:    p_sel = work_reg.item.point_x;
            2'd1:    p_sel = work_reg.item.point_y;
            default: p_sel = work_reg.item.point_z;
        endcase
        unique case (row_reg)
            2'd0:    t_sel = work_reg.item.trans_x;
            2'd1:    t_sel = work_reg.item.trans_y;
            default: t_sel = work_reg.item.trans_z;
        endcase
    end

    // Select multiplier operands
    always_comb
    begin
        opa = 50'(rot_sel);
        opb = 50'(p_sel);
        if (state_reg == ST_QMUL || state_reg == ST_QMUL_WAIT)
        begin
            unique case (qstep_reg)
                Q_AB:    begin opa = 50'(a_reg);           opb = 50'(b_reg);       end
                Q_AA:    begin opa = 50'(a_reg);           opb = 50'(a_reg);       end
                Q_BB:    begin opa = 50'(b_reg);           opb = 50'(b_reg);       end
                Q_AC:    begin opa = 50'(a_reg);           opb = 50'(c_reg);       end
                Q_BC:    begin opa = 50'(b_reg);           opb = 50'(c_reg);       end
                Q_PU:    begin opa = 50'(a_reg);           opb = 50'(cfg.focal_x); end
                Q_PV:    begin opa = 50'(b_reg);           opb = 50'(cfg.focal_y); end
                Q_JU0:   begin opa = 50'(ab_reg);          opb = 50'(cfg.focal_x); end
                Q_JU1:   begin opa = -(Q_ONE + 50'(aa_reg)); opb = 50'(cfg.focal_x); end
                Q_JU2:   begin opa = 50'(b_reg);           opb = 50'(cfg.focal_x); end
                Q_JU3:   begin opa = -50'(c_reg);          opb = 50'(cfg.focal_x); end
                Q_JU5:   begin opa = 50'(ac_reg);          opb = 50'(cfg.focal_x); end
                Q_JV0:   begin opa = Q_ONE + 50'(bb_reg);  opb = 50'(cfg.focal_y); end
                Q_JV1:   begin opa = -50'(ab_reg);         opb = 50'(cfg.focal_y); end
                Q_JV2:   begin opa = -50'(a_reg);          opb = 50'(cfg.focal_y); end
                Q_JV4:   begin opa = -50'(c_reg);          opb = 50'(cfg.focal_y); end
                Q_JV5:   begin opa = 50'(bc_reg);          opb = 50'(cfg.focal_y); end
                default: begin opa = '0;                   opb = '0;               end
            endcase
        end
        mag_a_full = opa[49] ? -opa : opa;
        mag_b_full = opb[49] ? -opb : opb;
        neg        = opa[49] ^ opb[49];
    end

    assign mul_start = (state_reg == ST_CAM) || (state_reg == ST_QMUL);
    assign div_start = (state_reg == ST_DIV);

    pjr_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .mag_a (mag_a_full[47:0]),
        .mag_b (mag_b_full[47:0]),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // Camera coordinate accumulate and round
    always_comb
    begin
        cam_prod  = neg ? -66'(mul_prod[63:0]) : 66'(mul_prod[63:0]);
        cam_sum   = acc_reg + cam_prod;
        cam_round = (cam_sum + ROUND26) >>> 26;
        cam_coord = 41'(cam_round) + 41'(t_sel);
    end

    // Round the product to Q16.16 and saturate
    always_comb
    begin
        q_rnd    = mul_prod + 96'd32768;
        q_mag    = (|q_rnd[95:63]) ? WIDE_MAX : q_rnd[63:16];
        qres     = neg ? -48'(q_mag) : 48'(q_mag);
        qsat     = sat32(50'(qres));
        if (qstep_reg == Q_PU)
        begin
            err_full = 50'(work_reg.item.meas_u)
                       - (50'(qres) + 50'($signed({1'b0, cfg.center_x})));
        end
        else
        begin
            err_full = 50'(work_reg.item.meas_v)
                       - (50'(qres) + 50'($signed({1'b0, cfg.center_y})));
        end
        err_sat = sat32(err_full);
    end

    // Divider operands and signed quotient
    always_comb
    begin
        unique case (dstep_reg)
            D_A:     dnum = x_reg;
            D_B:     dnum = y_reg;
            default: dnum = NUM_ONE;
        endcase
        dnum_mag = dnum[40] ? -dnum : dnum;
        d_mag    = (|div_quot[63:47]) ? WIDE_MAX : div_quot[47:0];
        dres     = dnum[40] ? -48'(d_mag) : 48'(d_mag);
    end

    pjr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (48'(dnum_mag)),
        .den   (z_reg[39:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign cam_step  = (state_reg == ST_CAM_WAIT) && mul_done;
    assign div_step  = (state_reg == ST_DIV_WAIT) && div_done;
    assign qmul_step = (state_reg == ST_QMUL_WAIT) && mul_done;
    assign work_pop  = (state_reg == ST_IDLE) && !work_empty;
    assign res_push  = ((state_reg == ST_OUT_U) || (state_reg == ST_OUT_V)) && !res_full;

    // Sequence one record through the shared units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dstep_reg <= D_A;
            qstep_reg <= Q_AB;
            row_reg   <= '0;
            col_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!work_empty)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        state_reg <= ST_CAM;
                    end
                end
                ST_CAM:
                begin
                    state_reg <= ST_CAM_WAIT;
                end
                ST_CAM_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (col_reg == 2'd2)
                        begin
                            col_reg <= '0;
                            if (row_reg == 2'd2)
                            begin
                                if (cam_coord <= 41'sd0)
                                begin
                                    bad_reg   <= 1'b1;
                                    state_reg <= ST_OUT_U;
                                end
                                else
                                begin
                                    bad_reg   <= 1'b0;
                                    dstep_reg <= D_A;
                                    state_reg <= ST_DIV;
                                end
                            end
                            else
                            begin
                                row_reg   <= row_reg + 1'b1;
                                state_reg <= ST_CAM;
                            end
                        end
                        else
                        begin
                            col_reg   <= col_reg + 1'b1;
                            state_reg <= ST_CAM;
                        end
                    end
                end
                ST_DIV:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        if (dstep_reg == D_C)
                        begin
                            qstep_reg <= Q_AB;
                            state_reg <= ST_QMUL;
                        end
                        else
                        begin
                            dstep_reg <= dstep_t'(dstep_reg + 1'b1);
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_QMUL:
                begin
                    state_reg <= ST_QMUL_WAIT;
                end
                ST_QMUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (qstep_reg == Q_JV5)
                        begin
                            state_reg <= ST_OUT_U;
                        end
                        else
                        begin
                            qstep_reg <= qstep_t'(qstep_reg + 1'b1);
                            state_reg <= ST_QMUL;
                        end
                    end
                end
                ST_OUT_U:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_OUT_V;
                    end
                end
                ST_OUT_V:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Capture datapath results
    always_ff @(posedge clk)
    begin
        if (work_pop)
        begin
            work_reg <= work;
            acc_reg  <= '0;
        end
        if (cam_step)
        begin
            if (col_reg == 2'd2)
            begin
                acc_reg <= '0;
                unique case (row_reg)
                    2'd0:    x_reg <= cam_coord;
                    2'd1:    y_reg <= cam_coord;
                    default: z_reg <= cam_coord;
                endcase
            end
            else
            begin
                acc_reg <= cam_sum;
            end
        end
        if (div_step)
        begin
            unique case (dstep_reg)
                D_A:     a_reg <= dres;
                D_B:     b_reg <= dres;
                default: c_reg <= dres;
            endcase
        end
        if (qmul_step)
        begin
            unique case (qstep_reg)
                Q_AB:    ab_reg  <= qres;
                Q_AA:    aa_reg  <= qres;
                Q_BB:    bb_reg  <= qres;
                Q_AC:    ac_reg  <= qres;
                Q_BC:    bc_reg  <= qres;
                Q_PU:    eu_reg  <= err_sat;
                Q_PV:    ev_reg  <= err_sat;
                Q_JU0:   ju0_reg <= qsat;
                Q_JU1:   ju1_reg <= qsat;
                Q_JU2:   ju2_reg <= qsat;
                Q_JU3:   ju3_reg <= qsat;
                Q_JU5:   ju5_reg <= qsat;
                Q_JV0:   jv0_reg <= qsat;
                Q_JV1:   jv1_reg <= qsat;
                Q_JV2:   jv2_reg <= qsat;
                Q_JV4:   jv4_reg <= qsat;
                default: jv5_reg <= qsat;
            endcase
        end
    end

    // Drive the result beat for the current row
    always_comb
    begin
        res.row_index = (state_reg == ST_OUT_V);
        res.last_row  = (state_reg == ST_OUT_V);
        res.depth_bad = bad_reg;
        if (bad_reg)
        begin
            res.error_value = '0;
            res.jac_rot_x   = '0;
            res.jac_rot_y   = '0;
            res.jac_rot_z   = '0;
            res.jac_trans_x = '0;
            res.jac_trans_y = '0;
            res.jac_trans_z = '0;
        end
        else if (state_reg == ST_OUT_V)
        begin
            res.error_value = ev_reg;
            res.jac_rot_x   = jv0_reg;
            res.jac_rot_y   = jv1_reg;
            res.jac_rot_z   = jv2_reg;
            res.jac_trans_x = '0;
            res.jac_trans_y = jv4_reg;
            res.jac_trans_z = jv5_reg;
        end
        else
        begin
            res.error_value = eu_reg;
            res.jac_rot_x   = ju0_reg;
            res.jac_rot_y   = ju1_reg;
            res.jac_rot_z   = ju2_reg;
            res.jac_trans_x = ju3_reg;
            res.jac_trans_y = '0;
            res.jac_trans_z = ju5_reg;
        end
    end

endmodule : pjr_back
`default_nettype wire

FILE: hdl/pinhole_reprojection_jacobian.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pinhole_reprojection_jacobian: reprojection error and pose Jacobian
// Input channel: push/full, one beat per world point with its pose and
// measured pixel. Result channel: empty/pop, two beats per input beat,
// the u row then the v row (last_row set on the second).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data. The
// intrinsics must be written by the user only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high. Each
// point runs through the 64-step shared divider (three quotients) and the
// 48 x 16 shared multiplier (26 products). A point with non-positive depth
// skips the division and products. The input side keeps accepting beats
// into its register stage and work queue while the back end runs.
// Reset clears all queues and the intrinsics to zero. When the receiver
// stalls the result queue fills, the sequencer holds its finished rows,
// and full rises once the work queue and input stage are occupied.
// ----------------------------------------------------------------------------
module pinhole_reprojection_jacobian #(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  pjr_pkg::item_t    item,
    output logic              empty,
    input  logic              pop,
    output pjr_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [30:0]       cfg_data
);
    import pjr_pkg::*;

    cfg_t    cfg_reg;
    work_t   work_in;
    work_t   work_out;
    logic    work_push;
    logic    work_full;
    logic    work_pop;
    logic    work_empty;
    result_t res_in;
    logic    res_push;
    logic    res_full;

    assign cfg_ready = 1'b1;

    // Write the intrinsics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FOCAL_X:  cfg_reg.focal_x  <= cfg_data;
                CFG_FOCAL_Y:  cfg_reg.focal_y  <= cfg_data;
                CFG_CENTER_X: cfg_reg.center_x <= cfg_data;
                CFG_CENTER_Y: cfg_reg.center_y <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    pjr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .work_push (work_push),
        .work_full (work_full),
        .work      (work_in)
    );

    pjr_fifo #(
        .WIDTH ($bits(work_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .full  (work_full),
        .wdata (work_in),
        .pop   (work_pop),
        .empty (work_empty),
        .rdata (work_out)
    );

    pjr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work_empty (work_empty),
        .work_pop   (work_pop),
        .work       (work_out),
        .cfg        (cfg_reg),
        .res_push   (res_push),
        .res_full   (res_full),
        .res        (res_in)
    );

    pjr_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_in),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );

    // A row marked depth_bad carries zero error_value, jac_rot_x and jac_trans_z
    a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.depth_bad) |->
            (result.error_value == 0 && result.jac_rot_x == 0 && result.jac_trans_z == 0))
        else $error("depth_bad row with nonzero values");

    // The unused translation entry of each row stays zero
    a_unused_zero : assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.row_index == 1'b0 && result.jac_trans_y == 0) ||
                    (result.row_index == 1'b1 && result.jac_trans_x == 0)))
        else $error("unused Jacobian entry nonzero");

    // Sequencer never pushes into a full result queue nor pops an empty work queue
    a_queue_flow : assert property (@(posedge clk) disable iff (!rst_n)
        (res_push |-> !res_full) and (work_pop |-> !work_empty))
        else $error("queue handshake violated inside block");

endmodule : pinhole_reprojection_jacobian
`default_nettype wire
